// File: rtl/hsk_pkg.sv
// Shared types and constants for the six-key report tracker.
package hsk_pkg;

   localparam int KEY_W       = 8;
   localparam int REPORT_KEYS = 6;

   typedef enum logic [2:0] {
      OP_PRESS       = 3'd0,
      OP_RELEASE     = 3'd1,
      OP_RELEASE_ALL = 3'd2,
      OP_SET_MOD     = 3'd3,
      OP_CLEAR_MOD   = 3'd4,
      OP_SEND        = 3'd5
   } op_type;

   typedef struct packed {
      logic             capture;
      logic             apply;
      op_type           op;
      logic [KEY_W-1:0] code;
      logic             hit_any;
   } cell_ctrl_type;

endpackage

// File: rtl/hsk_key_cell.sv
// One key slot of the held-key list, shifting toward its left neighbor on release.
module hsk_key_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  hsk_pkg::cell_ctrl_type       ctrl,
   input  logic                         prev_occupied,
   input  logic                         found_in,
   input  logic [hsk_pkg::KEY_W-1:0]    next_key,
   output logic [hsk_pkg::KEY_W-1:0]    key,
   output logic                         occupied,
   output logic                         match,
   output logic                         found_out
);

   logic [hsk_pkg::KEY_W-1:0] key_ff;
   logic [hsk_pkg::KEY_W-1:0] key_in;
   logic                      match_ff;
   logic                      match_in;

   always_comb begin
      match_in = match_ff;
      if (ctrl.capture) begin
         match_in = (key_ff == ctrl.code) && (ctrl.code != '0);
      end
   end

   always_comb begin
      key_in = key_ff;
      if (ctrl.apply) begin
         case (ctrl.op)
            hsk_pkg::OP_PRESS: begin
               if (!ctrl.hit_any && (ctrl.code != '0) && (key_ff == '0) && prev_occupied) begin
                  key_in = ctrl.code;
               end
            end
            hsk_pkg::OP_RELEASE: begin
               if (found_in || match_ff) begin
                  key_in = next_key;
               end
            end
            hsk_pkg::OP_RELEASE_ALL: begin
               key_in = '0;
            end
            default: begin
               key_in = key_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= '0;
         match_ff <= 1'b0;
      end else begin
         key_ff   <= key_in;
         match_ff <= match_in;
      end
   end

   assign key       = key_ff;
   assign occupied  = (key_ff != '0);
   assign match     = match_ff;
   assign found_out = found_in || match_ff;

endmodule

// File: rtl/hid_six_key_report_tracker.sv
// Top level of the boot-keyboard report tracker with its row of key slot cells.
//
// After start is taken, busy is high while a transaction runs through ST_MATCH, in which
// every slot compares its code with the command's key code, and then ST_APPLY, in which
// the slots update together and the send decision is made. A new transaction may be
// started as soon as busy is low. A send whose report differs from the last one
// sent puts the report on the rsp_ ports for exactly one cycle with rsp_valid high; the
// receiver cannot stall it, and it must take the report in that cycle.
module hid_six_key_report_tracker #(
   parameter int MAX_KEYS = 6
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [2:0]                req_op,
   input  logic [hsk_pkg::KEY_W-1:0] req_key_code,
   input  logic [hsk_pkg::KEY_W-1:0] req_modifier_bits,
   output logic                      rsp_valid,
   output logic [hsk_pkg::KEY_W-1:0] rsp_report_modifier,
   output logic [hsk_pkg::KEY_W-1:0] rsp_report_key_0,
   output logic [hsk_pkg::KEY_W-1:0] rsp_report_key_1,
   output logic [hsk_pkg::KEY_W-1:0] rsp_report_key_2,
   output logic [hsk_pkg::KEY_W-1:0] rsp_report_key_3,
   output logic [hsk_pkg::KEY_W-1:0] rsp_report_key_4,
   output logic [hsk_pkg::KEY_W-1:0] rsp_report_key_5
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_MATCH = 3'b010,
      ST_APPLY = 3'b100
   } state_type;

   state_type                 state_ff;
   state_type                 state_in;
   hsk_pkg::op_type           op_ff;
   logic [hsk_pkg::KEY_W-1:0] code_ff;
   logic [hsk_pkg::KEY_W-1:0] mod_ff;
   logic [hsk_pkg::KEY_W-1:0] cur_mod_ff;
   logic [hsk_pkg::KEY_W-1:0] cur_mod_in;
   logic [hsk_pkg::KEY_W-1:0] last_mod_ff;
   logic [hsk_pkg::KEY_W-1:0] last_keys_ff [hsk_pkg::REPORT_KEYS];
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [hsk_pkg::KEY_W-1:0] rsp_mod_ff;
   logic [hsk_pkg::KEY_W-1:0] rsp_keys_ff [hsk_pkg::REPORT_KEYS];

   logic                      accept;
   logic                      send_now;
   logic                      differs;
   logic [hsk_pkg::KEY_W-1:0] report_keys [hsk_pkg::REPORT_KEYS];

   hsk_pkg::cell_ctrl_type    ctrl;
   logic [hsk_pkg::KEY_W-1:0] keys [MAX_KEYS];
   logic [MAX_KEYS-1:0]       occupied;
   logic [MAX_KEYS-1:0]       prev_occ;
   logic [MAX_KEYS-1:0]       match_vec;
   logic [MAX_KEYS:0]         found;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl.capture = (state_ff == ST_MATCH);
      ctrl.apply   = (state_ff == ST_APPLY);
      ctrl.op      = op_ff;
      ctrl.code    = code_ff;
      ctrl.hit_any = |match_vec;
   end

   assign found[0] = 1'b0;

   for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign prev_occ[i] = 1'b1;
      end else begin : g_rest
         assign prev_occ[i] = occupied[i-1];
      end

      logic [hsk_pkg::KEY_W-1:0] next_key;
      if (i == MAX_KEYS - 1) begin : g_last
         assign next_key = '0;
      end else begin : g_mid
         assign next_key = keys[i+1];
      end

      hsk_key_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (ctrl),
         .prev_occupied (prev_occ[i]),
         .found_in      (found[i]),
         .next_key      (next_key),
         .key           (keys[i]),
         .occupied      (occupied[i]),
         .match         (match_vec[i]),
         .found_out     (found[i+1])
      );
   end

   always_comb begin
      for (int k = 0; k < hsk_pkg::REPORT_KEYS; k++) begin
         report_keys[k] = '0;
         if (k < MAX_KEYS) begin
            report_keys[k] = keys[k];
         end
      end
   end

   always_comb begin
      differs = (cur_mod_ff != last_mod_ff);
      for (int k = 0; k < hsk_pkg::REPORT_KEYS; k++) begin
         if (report_keys[k] != last_keys_ff[k]) begin
            differs = 1'b1;
         end
      end
   end

   assign send_now     = (state_ff == ST_APPLY) && (op_ff == hsk_pkg::OP_SEND);
   assign rsp_valid_in = send_now && differs;

   always_comb begin
      cur_mod_in = cur_mod_ff;
      if (state_ff == ST_APPLY) begin
         case (op_ff)
            hsk_pkg::OP_SET_MOD: begin
               cur_mod_in = mod_ff;
            end
            hsk_pkg::OP_CLEAR_MOD, hsk_pkg::OP_RELEASE_ALL: begin
               cur_mod_in = '0;
            end
            default: begin
               cur_mod_in = cur_mod_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_mod_ff   <= '0;
         last_mod_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < hsk_pkg::REPORT_KEYS; k++) begin
            last_keys_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cur_mod_ff   <= cur_mod_in;
         rsp_valid_ff <= rsp_valid_in;
         if (rsp_valid_in) begin
            last_mod_ff <= cur_mod_ff;
            for (int k = 0; k < hsk_pkg::REPORT_KEYS; k++) begin
               last_keys_ff[k] <= report_keys[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= hsk_pkg::op_type'(req_op);
         code_ff <= req_key_code;
         mod_ff  <= req_modifier_bits;
      end
      if (rsp_valid_in) begin
         rsp_mod_ff <= cur_mod_ff;
         for (int k = 0; k < hsk_pkg::REPORT_KEYS; k++) begin
            rsp_keys_ff[k] <= report_keys[k];
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_report_modifier = rsp_mod_ff;
   assign rsp_report_key_0    = rsp_keys_ff[0];
   assign rsp_report_key_1    = rsp_keys_ff[1];
   assign rsp_report_key_2    = rsp_keys_ff[2];
   assign rsp_report_key_3    = rsp_keys_ff[3];
   assign rsp_report_key_4    = rsp_keys_ff[4];
   assign rsp_report_key_5    = rsp_keys_ff[5];

   a_list_packed : assert property (@(posedge clock) disable iff (reset)
      (occupied & ~prev_occ) == '0)
      else $error("held key list has a gap");

   a_rsp_only_after_send : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff) == ST_APPLY) && ($past(op_ff) == hsk_pkg::OP_SEND))
      else $error("report emitted without a send");

   a_rsp_single_cycle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("report strobe held longer than one cycle");

   a_rsp_when_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("report strobe while a transaction is in progress");

   a_no_change_on_send : assert property (@(posedge clock) disable iff (reset)
      send_now |=> (cur_mod_ff == $past(cur_mod_ff)) && (keys[0] == $past(keys[0])))
      else $error("send altered the report state");

endmodule
